[rtl/core/at_cfp_pkg.sv]
// Shared types, constants and prefix tables for the AT command frame parser.
// No dependencies; used by at_cfp_prefix, at_cfp_number and the top level.
`default_nettype none

package at_cfp_pkg;

    localparam int unsigned NUM_PFX = 6;

    typedef enum logic [2:0] {
        KIND_TEST = 3'd0,
        KIND_MODE = 3'd1,
        KIND_M1CH = 3'd2,
        KIND_M2CH = 3'd3,
        KIND_BAUD = 3'd4,
        KIND_RATE = 3'd5
    } cmd_kind_t;

    // Prefix text, one 8-character string per command kind; first character in the MSBs.
    // The test prefix only compares its first two characters.
    localparam logic [NUM_PFX-1:0][63:0] PFX_TEXT = {
        "AT+RATE=", "AT+BAUD=", "AT+M2CH=", "AT+M1CH=", "AT+MODE=", "AT      "
    };

    localparam logic [3:0]  PFX_DONE    = 4'd8;
    localparam logic [20:0] ACC_MAX     = 21'h1FFFFF;
    localparam logic [20:0] MODE_MAX    = 21'd4;
    localparam logic [20:0] CHAN_MAX    = 21'd9;
    localparam logic [20:0] BAUD_MIN    = 21'd110;
    localparam logic [20:0] BAUD_MAX    = 21'd1000000;
    localparam logic [20:0] RATE_MAX    = 21'd10000;
    localparam logic [19:0] BAUD_RESET  = 20'd115200;
    localparam logic [2:0]  MODE_M1     = 3'd3;
    localparam logic [2:0]  MODE_M2     = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [7:0] ch;
        logic       number_enable;
        logic [5:0] candidates;
        logic [3:0] progress;
        logic [7:0] byte_count;
    } pfx_status_t;

    typedef struct packed {
        logic        negative;
        logic [20:0] accumulator;
    } num_status_t;

    function automatic logic [7:0] pfx_char(input logic [2:0] k, input logic [2:0] pos);
        logic [63:0] text;
        text = PFX_TEXT[k];
        return text[8*(7-pos) +: 8];
    endfunction

    function automatic logic [3:0] pfx_len(input logic [2:0] k);
        return (k == KIND_TEST) ? 4'd2 : 4'd8;
    endfunction

    function automatic logic [7:0] pfx_limit(input logic [2:0] k);
        logic [7:0] lim;
        case (k)
            KIND_TEST:                       lim = 8'd4;
            KIND_MODE, KIND_M1CH, KIND_M2CH: lim = 8'd15;
            default:                         lim = 8'd20;
        endcase
        return lim;
    endfunction

endpackage

`default_nettype wire

[rtl/core/at_cfp_prefix.sv]
// Prefix matcher: frame byte count, end-of-text tracking and prefix candidates.
// Depends on at_cfp_pkg.
`default_nettype none

module at_cfp_prefix (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic                    clear,
    input  wire logic [7:0]              rx_byte,
    output at_cfp_pkg::pfx_status_t      status
);

    logic [7:0] byte_count_reg, byte_count_next;
    logic [3:0] progress_reg, progress_next;
    logic [5:0] cand_reg, cand_next;
    logic       text_ended_reg, text_ended_next;
    logic [7:0] ch;

    always_comb
    begin
        // Bytes after a zero byte read as zero
        ch              = text_ended_reg ? 8'd0 : rx_byte;
        text_ended_next = text_ended_reg | (rx_byte == 8'd0);
        cand_next       = cand_reg;
        progress_next   = progress_reg;
        if (progress_reg < at_cfp_pkg::PFX_DONE)
        begin
            for (int k = 0; k < at_cfp_pkg::NUM_PFX; k++)
            begin
                if (cand_reg[k] && progress_reg < at_cfp_pkg::pfx_len(3'(k))
                    && ch != at_cfp_pkg::pfx_char(3'(k), progress_reg[2:0]))
                begin
                    cand_next[k] = 1'b0;
                end
            end
            progress_next = progress_reg + 4'd1;
        end
        byte_count_next = (byte_count_reg == 8'hFF) ? byte_count_reg : byte_count_reg + 8'd1;
    end

    assign status.ch            = ch;
    assign status.number_enable = (progress_reg == at_cfp_pkg::PFX_DONE);
    assign status.candidates    = cand_next;
    assign status.progress      = progress_next;
    assign status.byte_count    = byte_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            progress_reg   <= '0;
            cand_reg       <= '1;
            text_ended_reg <= 1'b0;
        end
        else if (step)
        begin
            if (clear)
            begin
                byte_count_reg <= '0;
                progress_reg   <= '0;
                cand_reg       <= '1;
                text_ended_reg <= 1'b0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                progress_reg   <= progress_next;
                cand_reg       <= cand_next;
                text_ended_reg <= text_ended_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/at_cfp_number.sv]
// Decimal value parser: whitespace skip, optional sign, saturating digit accumulator.
// Depends on at_cfp_pkg.
`default_nettype none

module at_cfp_number (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic                    clear,
    input  wire logic                    enable,
    input  wire logic [7:0]              ch,
    output at_cfp_pkg::num_status_t      status
);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGNED = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [20:0] acc_reg, acc_next;
    logic [24:0] acc_sum;
    logic [20:0] acc_digit;
    logic        is_digit, is_space, is_sign;

    always_comb
    begin
        is_digit  = (ch >= at_cfp_pkg::CH_ZERO) && (ch <= at_cfp_pkg::CH_NINE);
        is_space  = (ch == at_cfp_pkg::CH_SPACE)
                    || ((ch >= at_cfp_pkg::CH_TAB) && (ch <= at_cfp_pkg::CH_CR));
        is_sign   = (ch == at_cfp_pkg::CH_PLUS) || (ch == at_cfp_pkg::CH_MINUS);
        // acc * 10 + digit as two shifts and adds
        acc_sum   = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {21'd0, ch[3:0]};
        acc_digit = (acc_sum > {4'd0, at_cfp_pkg::ACC_MAX}) ? at_cfp_pkg::ACC_MAX
                                                             : acc_sum[20:0];
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (enable)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (is_space)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (is_sign)
                    begin
                        neg_next   = (ch == at_cfp_pkg::CH_MINUS);
                        phase_next = PH_SIGNED;
                    end
                    else if (is_digit)
                    begin
                        acc_next   = acc_digit;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SIGNED, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        acc_next   = acc_digit;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    assign status.negative    = neg_next;
    assign status.accumulator = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (step)
        begin
            if (clear)
            begin
                phase_reg <= PH_SKIP;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/at_command_frame_parser_unit.sv]
// Top level of the AT command frame parser: input register, settings, output register.
// Depends on at_cfp_pkg, at_cfp_prefix and at_cfp_number.
`default_nettype none

// Takes one frame byte per clock on the slave stream (tlast marks the last byte) and,
// on the last byte of a frame that matches AT, AT+MODE=, AT+M1CH=, AT+M2CH=, AT+BAUD=
// or AT+RATE= within that prefix's length limit, gives one reply item carrying OK or
// ERROR, the command kind and all stored settings after the frame. Frames that match
// nothing give no item. A byte is taken every cycle unless the input stalls as below;
// the last byte is held in the input register, then the reply is loaded into the output
// register when that byte is consumed. The input only stalls when a reply still
// waits in the output register and the byte held in the input register is the last of
// a frame.
module at_command_frame_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // end_of_frame
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [2:0] mode_value, [6:3] m1_channel,
                                             // [10:7] m2_channel, [30:11] baud_value,
                                             // [44:31] send_rate_value, [45] save_request,
                                             // [47:46] zero
    output logic [3:0]       m_axis_tuser    // [0] reply_error, [3:1] command_kind
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_free, consume, frame_done;

    at_cfp_pkg::pfx_status_t pfx_status;
    at_cfp_pkg::num_status_t num_status;

    logic [2:0]  mode_reg, mode_next;
    logic [3:0]  m1_reg, m1_next;
    logic [3:0]  m2_reg, m2_next;
    logic [19:0] baud_reg, baud_next;
    logic [13:0] rate_reg, rate_next;

    logic                  hit;
    at_cfp_pkg::cmd_kind_t kind;
    logic                  ok;
    logic [20:0]           acc;
    logic                  neg;

    logic                  out_valid_reg;
    logic                  out_err_reg;
    at_cfp_pkg::cmd_kind_t out_kind_reg;
    logic [2:0]            out_mode_reg;
    logic [3:0]            out_m1_reg;
    logic [3:0]            out_m2_reg;
    logic [19:0]           out_baud_reg;
    logic [13:0]           out_rate_reg;
    logic                  out_save_reg;

    assign out_free      = !out_valid_reg || m_axis_tready;
    // A byte that is not the last can always advance; a last byte needs the result slot
    assign consume       = in_valid_reg && (out_free || !in_last_reg);
    assign frame_done    = consume && in_last_reg;
    assign s_axis_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    at_cfp_prefix u_prefix (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (consume),
        .clear   (in_last_reg),
        .rx_byte (in_byte_reg),
        .status  (pfx_status)
    );

    at_cfp_number u_number (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (consume),
        .clear  (in_last_reg),
        .enable (pfx_status.number_enable),
        .ch     (pfx_status.ch),
        .status (num_status)
    );

    always_comb
    begin
        hit  = 1'b0;
        kind = at_cfp_pkg::KIND_TEST;
        // Scan from lowest priority up so the highest-priority match wins
        for (int k = at_cfp_pkg::NUM_PFX - 1; k >= 0; k--)
        begin
            if (pfx_status.candidates[k]
                && pfx_status.progress >= at_cfp_pkg::pfx_len(3'(k))
                && pfx_status.byte_count <= at_cfp_pkg::pfx_limit(3'(k)))
            begin
                hit  = 1'b1;
                kind = at_cfp_pkg::cmd_kind_t'(3'(k));
            end
        end

        acc       = num_status.accumulator;
        neg       = num_status.negative;
        ok        = 1'b1;
        mode_next = mode_reg;
        m1_next   = m1_reg;
        m2_next   = m2_reg;
        baud_next = baud_reg;
        rate_next = rate_reg;
        // A negative sign with a zero magnitude is plain zero
        unique case (kind)
            at_cfp_pkg::KIND_TEST:
            begin
                ok = 1'b1;
            end
            at_cfp_pkg::KIND_MODE:
            begin
                ok = neg ? (acc == 21'd0) : (acc <= at_cfp_pkg::MODE_MAX);
                if (ok)
                begin
                    mode_next = acc[2:0];
                end
            end
            at_cfp_pkg::KIND_M1CH:
            begin
                ok = neg ? (acc == 21'd0) : (acc <= at_cfp_pkg::CHAN_MAX);
                if (ok)
                begin
                    m1_next   = acc[3:0];
                    mode_next = at_cfp_pkg::MODE_M1;
                end
            end
            at_cfp_pkg::KIND_M2CH:
            begin
                ok = neg ? (acc == 21'd0) : (acc <= at_cfp_pkg::CHAN_MAX);
                if (ok)
                begin
                    m2_next   = acc[3:0];
                    mode_next = at_cfp_pkg::MODE_M2;
                end
            end
            at_cfp_pkg::KIND_BAUD:
            begin
                ok = !neg && (acc >= at_cfp_pkg::BAUD_MIN) && (acc <= at_cfp_pkg::BAUD_MAX);
                if (ok)
                begin
                    baud_next = acc[19:0];
                end
            end
            at_cfp_pkg::KIND_RATE:
            begin
                ok = neg ? (acc == 21'd0) : (acc <= at_cfp_pkg::RATE_MAX);
                if (ok)
                begin
                    rate_next = acc[13:0];
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= '0;
            m1_reg        <= '0;
            m2_reg        <= '0;
            baud_reg      <= at_cfp_pkg::BAUD_RESET;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_done && hit)
            begin
                mode_reg      <= mode_next;
                m1_reg        <= m1_next;
                m2_reg        <= m2_next;
                baud_reg      <= baud_next;
                rate_reg      <= rate_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done && hit)
        begin
            out_err_reg  <= !ok;
            out_kind_reg <= kind;
            out_mode_reg <= mode_next;
            out_m1_reg   <= m1_next;
            out_m2_reg   <= m2_next;
            out_baud_reg <= baud_next;
            out_rate_reg <= rate_next;
            out_save_reg <= ok && (kind != at_cfp_pkg::KIND_TEST);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_save_reg, out_rate_reg, out_baud_reg,
                            out_m2_reg, out_m1_reg, out_mode_reg};
    assign m_axis_tuser  = {out_kind_reg, out_err_reg};

`ifndef ASSERT_OFF
    a_done_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> out_free)
        else $error("last byte consumed while result slot occupied");

    a_save_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[45] ==
            (!m_axis_tuser[0] && (m_axis_tuser[3:1] != at_cfp_pkg::KIND_TEST))))
        else $error("save request disagrees with reply");

    a_m1_forces_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0] && m_axis_tuser[3:1] == at_cfp_pkg::KIND_M1CH)
        |-> (m_axis_tdata[2:0] == at_cfp_pkg::MODE_M1))
        else $error("accepted M1 channel did not force mode");

    a_baud_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[30:11] >= 20'd110
                           && m_axis_tdata[30:11] <= 20'd1000000))
        else $error("stored baud out of range");
`endif

endmodule

`default_nettype wire
